@@ rtl/gpl_pkg.sv @@
package gpl_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WRAP_MODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENTRIES    = 2'd2;

  localparam logic [31:0] FULL_SCALE_RST = 32'h0001_0000;

  // Item kinds.
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] position;
    logic [9:0]         entry_index;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
  } gpl_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } gpl_out_t;

  // Control that travels with every item down the pipeline.
  typedef struct packed {
    logic valid;
    logic write;
    logic neg;
    logic black;
  } gpl_ctl_t;

  // Palette write payload, carried so writes stay ordered with lookups.
  typedef struct packed {
    logic [9:0]  index;
    logic [23:0] rgb;
  } gpl_wr_t;

endpackage

@@ rtl/gpl_wrap.sv @@
module gpl_wrap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpl_pkg::gpl_ctl_t ctl_i,
  input  gpl_pkg::gpl_wr_t  wr_i,
  input  logic [30:0]       x_i,
  input  logic [31:0]       fs_i,
  input  logic              wrap_i,
  output gpl_pkg::gpl_ctl_t ctl_o,
  output gpl_pkg::gpl_wr_t  wr_o,
  output logic [31:0]       x_o
);

  // One position bit per stage for the modulo by full scale.
  localparam int unsigned Steps = 31;

  gpl_pkg::gpl_ctl_t ctl_q [Steps];
  gpl_pkg::gpl_wr_t  wr_q  [Steps];
  logic [30:0]       x_q   [Steps];
  logic [31:0]       rem_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    gpl_pkg::gpl_ctl_t ctl_in;
    gpl_pkg::gpl_wr_t  wr_in;
    logic [30:0]       x_in;
    logic [31:0]       rem_in;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic [31:0]       rem_d;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign wr_in  = wr_i;
      assign x_in   = x_i;
      assign rem_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign wr_in  = wr_q[s-1];
      assign x_in   = x_q[s-1];
      assign rem_in = rem_q[s-1];
    end

    assign trial = {rem_in, x_in[Steps-1-s]};
    assign diff  = trial - {1'b0, fs_i};
    assign rem_d = (trial >= {1'b0, fs_i}) ? diff[31:0] : trial[31:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      wr_q[s]  <= wr_in;
      x_q[s]   <= x_in;
      rem_q[s] <= rem_d;
    end
  end

  logic [31:0]       x_last;
  logic [31:0]       sel_d;
  logic [31:0]       sel_q;
  gpl_pkg::gpl_ctl_t sel_ctl_q;
  gpl_pkg::gpl_wr_t  sel_wr_q;

  assign x_last = {1'b0, x_q[Steps-1]};

  always_comb begin
    if (x_last > fs_i) begin
      sel_d = wrap_i ? rem_q[Steps-1] : fs_i;
    end else begin
      sel_d = x_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_ctl_q <= '0;
    end else begin
      sel_ctl_q <= ctl_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sel_wr_q <= wr_q[Steps-1];
    sel_q    <= sel_d;
  end

  assign ctl_o = sel_ctl_q;
  assign wr_o  = sel_wr_q;
  assign x_o   = sel_q;

endmodule

@@ rtl/gpl_scale.sv @@
module gpl_scale #(
  parameter int unsigned PALETTE_DEPTH = 1024,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gpl_pkg::gpl_ctl_t                      ctl_i,
  input  gpl_pkg::gpl_wr_t                       wr_i,
  input  logic [31:0]                            x_i,
  input  logic [$clog2(PALETTE_DEPTH+1)-1:0]     n_i,
  input  logic [31:0]                            fs_i,
  output gpl_pkg::gpl_ctl_t                      ctl_o,
  output gpl_pkg::gpl_wr_t                       wr_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0]       left_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0]       right_o,
  output logic [FRACTION_BITS-1:0]               frac_o
);

  localparam int unsigned NW = $clog2(PALETTE_DEPTH+1);
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned QW = NW + FRACTION_BITS;
  localparam int unsigned PW = 32 + NW;

  // Product stage.
  gpl_pkg::gpl_ctl_t mul_ctl_q;
  gpl_pkg::gpl_wr_t  mul_wr_q;
  logic [PW-1:0]     prod_d;
  logic [PW-1:0]     prod_q;

  assign prod_d = {{NW{1'b0}}, x_i} * {{32{1'b0}}, n_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ctl_q <= '0;
    end else begin
      mul_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_wr_q <= wr_i;
    prod_q   <= prod_d;
  end

  // Restoring divider, one quotient bit per stage. The low word shifts
  // dividend bits out at the top and quotient bits in at the bottom.
  gpl_pkg::gpl_ctl_t ctl_q [QW];
  gpl_pkg::gpl_wr_t  wr_q  [QW];
  logic [31:0]       rem_q [QW];
  logic [QW-1:0]     low_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    gpl_pkg::gpl_ctl_t ctl_in;
    gpl_pkg::gpl_wr_t  wr_in;
    logic [31:0]       rem_in;
    logic [QW-1:0]     low_in;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign ctl_in = mul_ctl_q;
      assign wr_in  = mul_wr_q;
      assign rem_in = prod_q[PW-1:NW];
      assign low_in = {prod_q[NW-1:0], {FRACTION_BITS{1'b0}}};
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign wr_in  = wr_q[s-1];
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, fs_i};
    assign ge    = (trial >= {1'b0, fs_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      wr_q[s]  <= wr_in;
      rem_q[s] <= ge ? diff[31:0] : trial[31:0];
      low_q[s] <= {low_in[QW-2:0], ge};
    end
  end

  // Clamp to entry 0 for a negative position or to the last entry, and split into address and fraction.
  logic [QW-1:0]     quot;
  logic [QW-1:0]     last;
  logic [QW-1:0]     pos;
  logic [NW-1:0]     left_w;
  logic [NW-1:0]     right_w;
  gpl_pkg::gpl_ctl_t out_ctl_q;
  gpl_pkg::gpl_wr_t  out_wr_q;
  logic [AW-1:0]     left_q;
  logic [AW-1:0]     right_q;
  logic [FRACTION_BITS-1:0] frac_q;

  assign quot    = low_q[QW-1];
  assign last    = {n_i - NW'(1), {FRACTION_BITS{1'b0}}};
  assign pos     = ctl_q[QW-1].neg ? '0 : ((quot > last) ? last : quot);
  assign left_w  = pos[QW-1:FRACTION_BITS];
  assign right_w = left_w + NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else begin
      out_ctl_q <= ctl_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_wr_q <= wr_q[QW-1];
    left_q   <= left_w[AW-1:0];
    right_q  <= (right_w >= n_i) ? left_w[AW-1:0] : right_w[AW-1:0];
    frac_q   <= pos[FRACTION_BITS-1:0];
  end

  assign ctl_o   = out_ctl_q;
  assign wr_o    = out_wr_q;
  assign left_o  = left_q;
  assign right_o = right_q;
  assign frac_o  = frac_q;

endmodule

@@ rtl/gpl_palette.sv @@
module gpl_palette #(
  parameter int unsigned PALETTE_DEPTH = 1024,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gpl_pkg::gpl_ctl_t                ctl_i,
  input  gpl_pkg::gpl_wr_t                 wr_i,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] left_i,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] right_i,
  input  logic [FRACTION_BITS-1:0]         frac_i,
  output logic                             valid_o,
  output gpl_pkg::gpl_out_t                result_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned SW = FRACTION_BITS + 9;
  localparam logic [FRACTION_BITS:0] One = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [23:0] mem [PALETTE_DEPTH];

  logic                     wr_ok;
  gpl_pkg::gpl_ctl_t        rd_ctl_q;
  logic [23:0]              lo_q;
  logic [23:0]              hi_q;
  logic [FRACTION_BITS-1:0] frac_q;

  assign wr_ok = (32'(wr_i.index) < 32'(PALETTE_DEPTH));

  // Writes and reads sit in the same stage, so every lookup sees exactly
  // the writes that were accepted before it.
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid && ctl_i.write && wr_ok) begin
      mem[AW'(wr_i.index)] <= wr_i.rgb;
    end
    lo_q   <= mem[left_i];
    hi_q   <= mem[right_i];
    frac_q <= frac_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q <= ctl_i;
    end
  end

  logic [FRACTION_BITS:0] inv_frac;
  logic [23:0]            blend;

  assign inv_frac = One - {1'b0, frac_q};

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [SW-1:0] sum;
    assign sum = SW'(hi_q[8*c +: 8]) * SW'(frac_q) + SW'(lo_q[8*c +: 8]) * SW'(inv_frac);
    assign blend[8*c +: 8] = sum[FRACTION_BITS +: 8];
  end

  logic              valid_q;
  gpl_pkg::gpl_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rd_ctl_q.valid && !rd_ctl_q.write;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= rd_ctl_q.black ? '0 : blend;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

@@ rtl/gradient_palette_lookup.sv @@
// Items pass the input register, the modulo stages and select, the product, divider and clamp
// stages, then the palette read and blend registers before the result strobe.
// Throughput: one item per cycle, lookups and palette writes alike; busy_o stays low.
// A write produces no result; a lookup produces one strobe the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the pipeline valid bits and loads the
// registers with full scale 1.0, clamp mode and no entries; palette contents are not cleared.
module gradient_palette_lookup #(
  parameter int unsigned PALETTE_DEPTH = 1024,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  gpl_pkg::gpl_in_t               item_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gpl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           result_valid_o,
  output gpl_pkg::gpl_out_t              result_o
);

  localparam int unsigned NW = $clog2(PALETTE_DEPTH+1);
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned QW = NW + FRACTION_BITS;
  // Input register, modulo pipeline plus select, product plus divider plus
  // clamp, palette read plus blend.
  localparam int unsigned Latency = 1 + 32 + (QW + 2) + 2;

  // Configuration registers. They must only be written while the pipeline is
  // empty, which the block itself does not enforce, so every stage reads them directly.
  logic [31:0] full_scale_q;
  logic        wrap_mode_q;
  logic [10:0] entries_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= gpl_pkg::FULL_SCALE_RST;
      wrap_mode_q  <= 1'b0;
      entries_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gpl_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        gpl_pkg::CFG_WRAP_MODE:  wrap_mode_q  <= cfg_data_i[0];
        gpl_pkg::CFG_ENTRIES:    entries_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // A full scale of zero behaves as one; the entry count saturates at the
  // palette depth.
  logic [31:0]   fs_eff;
  logic [NW-1:0] n_eff;

  assign fs_eff = (full_scale_q == '0) ? 32'd1 : full_scale_q;
  assign n_eff  = ({21'd0, entries_q} > 32'(PALETTE_DEPTH)) ? NW'(PALETTE_DEPTH)
                                                            : NW'(entries_q);

  // Every cycle can take a new item; the pipeline never stalls.
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register. The control word records the kind of item and the two
  // cases that bypass interpolation: a negative position, which reads
  // entry 0, and an empty palette, which yields black.
  gpl_pkg::gpl_ctl_t in_ctl_q;
  gpl_pkg::gpl_wr_t  in_wr_q;
  logic [30:0]       in_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q.valid <= accept;
      in_ctl_q.write <= (item_i.kind == gpl_pkg::KIND_WRITE);
      in_ctl_q.neg   <= item_i.position[31];
      in_ctl_q.black <= (n_eff == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    in_wr_q.index <= item_i.entry_index;
    in_wr_q.rgb   <= {item_i.entry_red, item_i.entry_green, item_i.entry_blue};
    in_x_q        <= item_i.position[30:0];
  end

  // Range reduction: positions above full scale wrap or clamp.
  gpl_pkg::gpl_ctl_t wrap_ctl;
  gpl_pkg::gpl_wr_t  wrap_wr;
  logic [31:0]       wrap_x;

  gpl_wrap u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (in_ctl_q),
    .wr_i   (in_wr_q),
    .x_i    (in_x_q),
    .fs_i   (fs_eff),
    .wrap_i (wrap_mode_q),
    .ctl_o  (wrap_ctl),
    .wr_o   (wrap_wr),
    .x_o    (wrap_x)
  );

  // Scaling: position * entries / full scale with fraction bits, clamped
  // to entry 0 for a negative position and to the last entry in use.
  gpl_pkg::gpl_ctl_t scl_ctl;
  gpl_pkg::gpl_wr_t  scl_wr;
  logic [AW-1:0]     scl_left;
  logic [AW-1:0]     scl_right;
  logic [FRACTION_BITS-1:0] scl_frac;

  gpl_scale #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (wrap_ctl),
    .wr_i    (wrap_wr),
    .x_i     (wrap_x),
    .n_i     (n_eff),
    .fs_i    (fs_eff),
    .ctl_o   (scl_ctl),
    .wr_o    (scl_wr),
    .left_o  (scl_left),
    .right_o (scl_right),
    .frac_o  (scl_frac)
  );

  // Palette memory and per-channel blend. Palette writes take effect here,
  // in item order with the lookups.
  gpl_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_palette (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scl_ctl),
    .wr_i     (scl_wr),
    .left_i   (scl_left),
    .right_i  (scl_right),
    .frac_i   (scl_frac),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

`ifndef SYNTH
  // Every accepted lookup yields a strobe.
  a_lookup_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind == gpl_pkg::KIND_LOOKUP) |-> ##Latency result_valid_o)
    else $error("accepted lookup produced no result");

  // An accepted palette write never yields a strobe.
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind == gpl_pkg::KIND_WRITE) |-> ##Latency !result_valid_o)
    else $error("palette write produced a result");

  // No strobe appears without a matching accepted lookup.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      $past(accept && item_i.kind == gpl_pkg::KIND_LOOKUP, Latency))
    else $error("result without a matching lookup");

  // With no entries in use the result is black.
  a_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && entries_q == '0) |-> (result_o == '0))
    else $error("empty palette did not give black");
`endif

endmodule
